/* sv/granular_grain_voice_defines.svh */
// Assertion macros for the top-level file that checks this block.
`ifndef GRANULAR_GRAIN_VOICE_DEFINES_SVH
`define GRANULAR_GRAIN_VOICE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/gv_pkg.sv */
package gv_pkg;

   localparam int SAMPLE_DEPTH = 65536;
   localparam int WINDOW_DEPTH = 1024;

   localparam int SAW    = $clog2(SAMPLE_DEPTH);
   localparam int WAW    = $clog2(WINDOW_DEPTH);
   localparam int SLEN_W = SAW + 1;
   localparam int WLEN_W = WAW + 1;
   localparam int POS_W  = SAW + 16;
   localparam int WP_W   = WAW + 16;
   localparam int WWR_W  = WLEN_W + 16;
   localparam int RAW_W  = 17 + 24;
   localparam int DVD_W  = (RAW_W > WWR_W) ? RAW_W : WWR_W;
   localparam int DVS_W  = ((SLEN_W > WLEN_W) ? SLEN_W : WLEN_W) + 16;

   localparam logic [1:0] REQ_SAMPLE   = 2'd0;
   localparam logic [1:0] REQ_WINDOW   = 2'd1;
   localparam logic [1:0] REQ_ACTIVATE = 2'd2;
   localparam logic [1:0] REQ_TICK     = 2'd3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_ONSET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GSIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WLEN  = 3'd4;

   localparam logic [1:0] DIV_POS  = 2'd0;
   localparam logic [1:0] DIV_WMOD = 2'd1;
   localparam logic [1:0] DIV_STEP = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [15:0]        mem_index;
      logic signed [15:0] data_word;
      logic signed [23:0] mix_in;
   } req_item_type;

   typedef struct packed {
      logic signed [23:0] mix_out;
      logic               grain_inactive;
   } rsp_item_type;

   typedef struct packed {
      logic       capture;
      logic       pos_mul;
      logic       div_start;
      logic [1:0] div_sel;
      logic       cap_pos;
      logic       cap_wmod;
      logic       cap_step;
      logic       rd_lo;
      logic       rd_hi;
      logic       mul_lo;
      logic       mul_hi;
      logic       interp_sum;
      logic       gain_mul;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic tick_active;
      logic div_done;
   } sts_type;

endpackage

/* sv/gv_div.sv */
module gv_div
   import gv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quot,
   output logic [DVS_W-1:0] rem
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W:0]   trial;
   logic             ge;
   logic [DVS_W:0]   diff;
   logic [DVS_W-1:0] rem_in;

   assign trial  = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign diff   = trial - {1'b0, dvs_ff};
   assign rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = dvd_ff;
   assign rem  = rem_ff;

endmodule

/* sv/gv_dp.sv */
module gv_dp
   import gv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_item_type          req_data,
   input  cmd_type               cmd,
   output sts_type               sts,
   output rsp_item_type          rsp_data
);

   // Configuration registers.
   logic [15:0] onset_ff;
   logic [23:0] speed_ff;
   logic [15:0] gsize_ff;
   logic [16:0] slen_cfg_ff;
   logic [10:0] wlen_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         onset_ff    <= 16'd0;
         speed_ff    <= 24'd65536;
         gsize_ff    <= 16'd1024;
         slen_cfg_ff <= 17'd65536;
         wlen_cfg_ff <= 11'd1024;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ONSET: onset_ff    <= csr_wdata[15:0];
            CSR_SPEED: speed_ff    <= csr_wdata;
            CSR_GSIZE: gsize_ff    <= csr_wdata[15:0];
            CSR_SLEN:  slen_cfg_ff <= csr_wdata[16:0];
            CSR_WLEN:  wlen_cfg_ff <= csr_wdata[10:0];
            default:   ;
         endcase
      end
   end

   // Effective lengths: zero acts as one, and lengths clamp to the memory depth.
   logic [SLEN_W-1:0] slen;
   logic [WLEN_W-1:0] wlen;
   logic [15:0]       gsz;
   logic [WWR_W-1:0]  wwrap;

   always_comb begin
      if (slen_cfg_ff == 17'd0) slen = SLEN_W'(1);
      else if (32'(slen_cfg_ff) > 32'(SAMPLE_DEPTH)) slen = SLEN_W'(SAMPLE_DEPTH);
      else slen = SLEN_W'(slen_cfg_ff);
      if (wlen_cfg_ff == 11'd0) wlen = WLEN_W'(1);
      else if (32'(wlen_cfg_ff) > 32'(WINDOW_DEPTH)) wlen = WLEN_W'(WINDOW_DEPTH);
      else wlen = WLEN_W'(wlen_cfg_ff);
      gsz   = (gsize_ff == 16'd0) ? 16'd1 : gsize_ff;
      wwrap = {wlen, 16'd0};
   end

   // Grain state.
   logic [15:0]     gphase_ff;
   logic [WP_W-1:0] wphase_ff;
   logic            inactive_ff;

   // Captured request and working registers.
   req_item_type      req_ff;
   logic [RAW_W-1:0]  raw_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [WP_W-1:0]   wmod_ff;
   logic [WP_W:0]     step_ff;
   logic signed [33:0] ps_ff, pw_ff, hs_ff, hw_ff;
   logic signed [15:0] smp_ff, gain_ff;
   logic signed [31:0] prod_ff;
   rsp_item_type      rsp_ff;

   // Status back to the controller.
   logic tick_active;
   logic div_done;

   assign tick_active = (req_data.req_type == REQ_TICK) && !inactive_ff;
   assign sts         = '{tick_active: tick_active, div_done: div_done};

   // Shared iterative divider.
   logic [DVD_W-1:0] div_dvd;
   logic [DVS_W-1:0] div_dvs;
   logic [DVD_W-1:0] div_q;
   logic [DVS_W-1:0] div_r;

   always_comb begin
      case (cmd.div_sel)
         DIV_POS: begin
            div_dvd = DVD_W'(raw_ff);
            div_dvs = DVS_W'({slen, 16'd0});
         end
         DIV_WMOD: begin
            div_dvd = DVD_W'(wphase_ff);
            div_dvs = DVS_W'(wwrap);
         end
         default: begin
            div_dvd = DVD_W'(wwrap);
            div_dvs = DVS_W'(gsz);
         end
      endcase
   end

   gv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   // Memory addressing and interpolation fractions.
   logic [SAW-1:0]    s_lo, s_hi;
   logic [WAW-1:0]    w_lo, w_hi;
   logic [SLEN_W-1:0] s_lo1;
   logic [WLEN_W-1:0] w_lo1;
   logic [15:0]       s_fr, w_fr;

   always_comb begin
      s_lo  = pos_ff[POS_W-1:16];
      s_fr  = pos_ff[15:0];
      s_lo1 = SLEN_W'(s_lo) + 1'b1;
      s_hi  = (s_lo1 >= slen) ? '0 : s_lo1[SAW-1:0];
      w_lo  = wmod_ff[WP_W-1:16];
      w_fr  = wmod_ff[15:0];
      w_lo1 = WLEN_W'(w_lo) + 1'b1;
      w_hi  = (w_lo1 >= wlen) ? '0 : w_lo1[WAW-1:0];
   end

   // Sample and window memories, one port each, registered read.
   logic signed [15:0] sample_mem [SAMPLE_DEPTH];
   logic signed [15:0] window_mem [WINDOW_DEPTH];
   logic signed [15:0] s_rd_ff, w_rd_ff;
   logic               s_we, w_we;

   assign s_we = cmd.commit && (req_ff.req_type == REQ_SAMPLE)
                 && (32'(req_ff.mem_index) < 32'(SAMPLE_DEPTH));
   assign w_we = cmd.commit && (req_ff.req_type == REQ_WINDOW)
                 && (32'(req_ff.mem_index) < 32'(WINDOW_DEPTH));

   always_ff @(posedge clock) begin
      if (s_we) sample_mem[SAW'(req_ff.mem_index)] <= req_ff.data_word;
      if (cmd.rd_lo) s_rd_ff <= sample_mem[s_lo];
      else if (cmd.rd_hi) s_rd_ff <= sample_mem[s_hi];
   end

   always_ff @(posedge clock) begin
      if (w_we) window_mem[WAW'(req_ff.mem_index)] <= req_ff.data_word;
      if (cmd.rd_lo) w_rd_ff <= window_mem[w_lo];
      else if (cmd.rd_hi) w_rd_ff <= window_mem[w_hi];
   end

   // Interpolation and mixing arithmetic.
   logic signed [17:0] s_wlo, w_wlo, s_whi, w_whi;
   logic signed [34:0] s_acc, w_acc;
   logic signed [32:0] prod_rnd;
   logic signed [24:0] sum;
   logic signed [23:0] sat;

   always_comb begin
      s_wlo    = $signed(18'(17'd65536 - 17'(s_fr)));
      w_wlo    = $signed(18'(17'd65536 - 17'(w_fr)));
      s_whi    = $signed({2'b00, s_fr});
      w_whi    = $signed({2'b00, w_fr});
      s_acc    = 35'(ps_ff) + 35'(hs_ff) + 35'sd32768;
      w_acc    = 35'(pw_ff) + 35'(hw_ff) + 35'sd32768;
      prod_rnd = 33'(prod_ff) + 33'sd16384;
      sum      = 25'(req_ff.mix_in) + 25'($signed(prod_rnd[32:15]));
      if (sum > 25'sd8388607) sat = 24'sh7FFFFF;
      else if (sum < -25'sd8388608) sat = 24'sh800000;
      else sat = sum[23:0];
   end

   // Phase advance.
   logic [WP_W:0]  wsum;
   logic [WP_W-1:0] wnext;
   logic [16:0]    gnext;

   always_comb begin
      wsum  = {1'b0, wmod_ff} + step_ff;
      wnext = (32'(wsum) >= 32'(wwrap)) ? WP_W'(wsum - (WP_W+1)'(wwrap)) : wsum[WP_W-1:0];
      gnext = {1'b0, gphase_ff} + 17'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.pos_mul) raw_ff <= RAW_W'((17'(onset_ff) + 17'(gphase_ff)) * 41'(speed_ff));
      if (cmd.cap_pos) pos_ff <= div_r[POS_W-1:0];
      if (cmd.cap_wmod) wmod_ff <= div_r[WP_W-1:0];
      if (cmd.cap_step) step_ff <= div_q[WP_W:0];
      if (cmd.mul_lo) begin
         ps_ff <= 34'(s_rd_ff) * 34'(s_wlo);
         pw_ff <= 34'(w_rd_ff) * 34'(w_wlo);
      end
      if (cmd.mul_hi) begin
         hs_ff <= 34'(s_rd_ff) * 34'(s_whi);
         hw_ff <= 34'(w_rd_ff) * 34'(w_whi);
      end
      if (cmd.interp_sum) begin
         smp_ff  <= s_acc[31:16];
         gain_ff <= w_acc[31:16];
      end
      if (cmd.gain_mul) prod_ff <= gain_ff * smp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gphase_ff   <= '0;
         wphase_ff   <= '0;
         inactive_ff <= 1'b1;
      end else if (cmd.commit) begin
         if (req_ff.req_type == REQ_ACTIVATE) begin
            inactive_ff <= 1'b0;
         end else if (req_ff.req_type == REQ_TICK && !inactive_ff) begin
            if (gnext >= 17'(gsz)) begin
               inactive_ff <= 1'b1;
               gphase_ff   <= '0;
               wphase_ff   <= '0;
            end else begin
               gphase_ff <= gnext[15:0];
               wphase_ff <= wnext;
            end
         end
      end
   end

   logic done_inactive;
   assign done_inactive = (req_ff.req_type == REQ_ACTIVATE) ? 1'b0 :
                          (req_ff.req_type == REQ_TICK && !inactive_ff) ?
                          (gnext >= 17'(gsz)) : inactive_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.grain_inactive <= done_inactive;
         if (req_ff.req_type != REQ_TICK) rsp_ff.mix_out <= '0;
         else if (inactive_ff) rsp_ff.mix_out <= req_ff.mix_in;
         else rsp_ff.mix_out <= sat;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* sv/gv_ctrl.sv */
module gv_ctrl
   import gv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MULT   = 4'd1;
   localparam logic [3:0] ST_POS_GO = 4'd2;
   localparam logic [3:0] ST_POS_WT = 4'd3;
   localparam logic [3:0] ST_WMD_GO = 4'd4;
   localparam logic [3:0] ST_WMD_WT = 4'd5;
   localparam logic [3:0] ST_STP_GO = 4'd6;
   localparam logic [3:0] ST_STP_WT = 4'd7;
   localparam logic [3:0] ST_RD_LO  = 4'd8;
   localparam logic [3:0] ST_RD_HI  = 4'd9;
   localparam logic [3:0] ST_MUL_HI = 4'd10;
   localparam logic [3:0] ST_SUM    = 4'd11;
   localparam logic [3:0] ST_PROD   = 4'd12;
   localparam logic [3:0] ST_FIN    = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff;
   logic       accept, out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      cmd.div_sel  = DIV_POS;
      state_in     = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) state_in = sts.tick_active ? ST_MULT : ST_FIN;
         end
         ST_MULT: begin
            cmd.pos_mul = 1'b1;
            state_in    = ST_POS_GO;
         end
         ST_POS_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_POS_WT;
         end
         ST_POS_WT: begin
            cmd.cap_pos = sts.div_done;
            if (sts.div_done) state_in = ST_WMD_GO;
         end
         ST_WMD_GO: begin
            cmd.div_sel   = DIV_WMOD;
            cmd.div_start = 1'b1;
            state_in      = ST_WMD_WT;
         end
         ST_WMD_WT: begin
            cmd.cap_wmod = sts.div_done;
            if (sts.div_done) state_in = ST_STP_GO;
         end
         ST_STP_GO: begin
            cmd.div_sel   = DIV_STEP;
            cmd.div_start = 1'b1;
            state_in      = ST_STP_WT;
         end
         ST_STP_WT: begin
            cmd.cap_step = sts.div_done;
            if (sts.div_done) state_in = ST_RD_LO;
         end
         ST_RD_LO: begin
            cmd.rd_lo = 1'b1;
            state_in  = ST_RD_HI;
         end
         ST_RD_HI: begin
            cmd.rd_hi  = 1'b1;
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.interp_sum = 1'b1;
            state_in       = ST_PROD;
         end
         ST_PROD: begin
            cmd.gain_mul = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            cmd.commit = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.commit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/granular_grain_voice.sv */
// One granular-synthesis grain voice.
// The request channel (req_valid, req_stall, req_data) carries one transaction per
// item: a sample memory write, a window memory write, a grain activation or an output
// tick. The response channel (rsp_valid, rsp_stall, rsp_data) returns exactly one
// transaction for every request, in order. Configuration registers must be written
// through csr_we, csr_index and csr_wdata while the voice is idle; the voice
// itself does not enforce this. Memory writes, activations and ticks on an inactive
// grain go from acceptance straight to the final step, which loads the response
// register. A tick on an active grain first runs one shared shift-subtract divider
// three times, each pass 41 shift steps from start to capture (read position
// modulo the sample length, window phase modulo the window length, and the window
// step), followed by two reads of each single-port memory and the multiply stages.
// A new request is taken once the previous one has been placed in the response
// register, so a waiting response does not block the next request.
// If the receiver stalls, the response register holds its transaction and the
// voice waits in its final step with the next result until that register frees.
// Synchronous reset returns the configuration to its defaults, clears both phases
// and marks the grain inactive; memory contents are not cleared.
`include "granular_grain_voice_defines.svh"

module granular_grain_voice
   import gv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Commands flow from the sequencer to the datapath, status flows back.
   cmd_type cmd;
   sts_type sts;

   gv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gv_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

   // An accepted transaction makes the voice busy in the cycle after it is accepted.
   `GV_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "voice idle right after accepting a transaction")

   // A new response only appears after the voice has been busy working on it.
   `GV_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "response appeared without a busy cycle before it")

endmodule
